// ===== hdl/fgd_pkg.sv =====
// Shared types and constants for the footswitch gesture detector.
// No dependencies; every other file in hdl/ imports this package.
package fgd_pkg;

  // Fixed widths of the poll and result fields
  localparam int unsigned FieldW      = 4;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned CfgW        = 16;
  localparam int unsigned CountW      = 2;
  localparam int unsigned NumSwitchesDef = 4;

  // APB register map: register i at byte address 4*i
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = 2;

  localparam logic [RegIdxW-1:0] RegDebounce  = 2'd0;
  localparam logic [RegIdxW-1:0] RegLongPress = 2'd1;
  localparam logic [RegIdxW-1:0] RegClickGap  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] DebounceRst  = 16'd20;
  localparam logic [CfgW-1:0] LongPressRst = 16'd800;
  localparam logic [CfgW-1:0] ClickGapRst  = 16'd350;

  // Click counter codes
  localparam logic [CountW-1:0] CountNone   = 2'd0;
  localparam logic [CountW-1:0] CountSingle = 2'd1;
  localparam logic [CountW-1:0] CountDouble = 2'd2;
  localparam logic [CountW-1:0] CountMax    = 2'd3;

  typedef struct packed {
    logic [CfgW-1:0] debounce_time;
    logic [CfgW-1:0] long_press_time;
    logic [CfgW-1:0] multi_click_gap;
  } cfg_t;

  // What one lane reports for the current poll
  typedef struct packed {
    logic pressed;
    logic dbl;
    logic lng;
    logic dlng;
  } lane_res_t;

  // One result beat
  typedef struct packed {
    logic [FieldW-1:0] pressed_mask;
    logic [FieldW-1:0] double_events;
    logic [FieldW-1:0] long_events;
    logic [FieldW-1:0] double_long_events;
  } result_t;

endpackage

// ===== hdl/fgd_regs.sv =====
// APB configuration registers of the footswitch gesture detector.
// Depends on fgd_pkg for the register map, reset values and cfg_t.
module fgd_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fgd_pkg::ApbAddrW-1:0]   paddr,
  input  logic [fgd_pkg::ApbDataW-1:0]   pwdata,
  output logic [fgd_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,
  output fgd_pkg::cfg_t                  cfg_o
);
  import fgd_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic [RegIdxW-1:0] idx;
  logic              wr_en;
  logic [CfgW-1:0]   rd_val;

  assign pready = 1'b1;
  assign idx    = paddr[RegIdxW+1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // Decode the write beat
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegDebounce:  cfg_d.debounce_time   = pwdata[CfgW-1:0];
        RegLongPress: cfg_d.long_press_time = pwdata[CfgW-1:0];
        RegClickGap:  cfg_d.multi_click_gap = pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time   <= DebounceRst;
      cfg_q.long_press_time <= LongPressRst;
      cfg_q.multi_click_gap <= ClickGapRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      RegDebounce:  rd_val = cfg_q.debounce_time;
      RegLongPress: rd_val = cfg_q.long_press_time;
      RegClickGap:  rd_val = cfg_q.multi_click_gap;
      default:      rd_val = '0;
    endcase
  end

  assign prdata = {{(ApbDataW-CfgW){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

endmodule

// ===== hdl/fgd_lane.sv =====
// One switch lane: debounce, click counting and hold timing for one pin.
// Depends on fgd_pkg for widths, counter codes, cfg_t and lane_res_t.
module fgd_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [fgd_pkg::TimeW-1:0]   now_i,
  input  logic                        raw_pressed_i,
  input  fgd_pkg::cfg_t               cfg_i,
  output fgd_pkg::lane_res_t          res_o
);
  import fgd_pkg::*;

  logic              pressed_q, pressed_d;
  logic [TimeW-1:0]  last_change_q, last_change_d;
  logic [TimeW-1:0]  last_press_q, last_press_d;
  logic [CountW-1:0] count_q, count_d;

  logic [TimeW-1:0]  since_change;
  logic [TimeW-1:0]  since_press;
  logic              settled;
  logic              gap_exceeded;
  logic              held_long;
  logic              change;
  lane_res_t         res;

  // Elapsed times, modulo 2^32
  assign since_change = now_i - last_change_q;
  assign since_press  = now_i - last_press_q;
  assign settled      = since_change >= {{(TimeW-CfgW){1'b0}}, cfg_i.debounce_time};
  assign gap_exceeded = since_press > {{(TimeW-CfgW){1'b0}}, cfg_i.multi_click_gap};
  assign held_long    = since_press >= {{(TimeW-CfgW){1'b0}}, cfg_i.long_press_time};
  assign change       = (raw_pressed_i != pressed_q) && settled;

  // Advance the lane state on an accepted level change
  always_comb begin
    pressed_d     = pressed_q;
    last_change_d = last_change_q;
    last_press_d  = last_press_q;
    count_d       = count_q;
    res           = '0;
    if (change) begin
      pressed_d     = raw_pressed_i;
      last_change_d = now_i;
      if (raw_pressed_i) begin
        last_press_d = now_i;
        if (gap_exceeded) begin
          count_d = CountSingle;
        end else begin
          if (count_q != CountMax) begin
            count_d = count_q + 1'b1;
          end
          res.dbl = (count_d == CountDouble);
        end
      end else if (held_long) begin
        res.lng  = (count_q == CountSingle);
        res.dlng = (count_q == CountDouble);
        count_d  = CountNone;
      end
    end
    res.pressed = pressed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q     <= 1'b0;
      last_change_q <= '0;
      last_press_q  <= '0;
      count_q       <= CountNone;
    end else if (accept_i) begin
      pressed_q     <= pressed_d;
      last_change_q <= last_change_d;
      last_press_q  <= last_press_d;
      count_q       <= count_d;
    end
  end

  assign res_o = accept_i ? res : '0;

  // A debounced press always leaves at least one click counted
  a_press_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pressed_q) |-> (count_q != CountNone))
    else $error("press accepted without a click count");

  // A level change stamps the poll time
  a_change_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && change) |=> (last_change_q == $past(now_i)))
    else $error("level change did not record its timestamp");

  // No poll, no state change
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> ($stable(pressed_q) && $stable(count_q) && $stable(last_press_q)))
    else $error("lane state moved without a poll");

endmodule

// ===== hdl/fgd_merge.sv =====
// Merge stage: gathers lane reports into one result beat and buffers it
// in an output register plus skid register. Depends on fgd_pkg.
module fgd_merge #(
  parameter int unsigned NumSwitches = fgd_pkg::NumSwitchesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  accept_o,
  input  fgd_pkg::lane_res_t    lane_res_i [NumSwitches],
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fgd_pkg::result_t      result_o
);
  import fgd_pkg::*;

  result_t merged;
  result_t out_q, skid_q;
  logic    out_vld_q, skid_vld_q;
  logic    accept;
  logic    out_take;

  // Collect the visible lanes; lanes beyond the field width stay hidden
  for (genvar j = 0; j < FieldW; j++) begin : g_bit
    if (j < NumSwitches) begin : g_lane
      assign merged.pressed_mask[j]       = lane_res_i[j].pressed;
      assign merged.double_events[j]      = lane_res_i[j].dbl;
      assign merged.long_events[j]        = lane_res_i[j].lng;
      assign merged.double_long_events[j] = lane_res_i[j].dlng;
    end else begin : g_none
      assign merged.pressed_mask[j]       = 1'b0;
      assign merged.double_events[j]      = 1'b0;
      assign merged.long_events[j]        = 1'b0;
      assign merged.double_long_events[j] = 1'b0;
    end
  end

  assign in_stall_o = skid_vld_q;
  assign accept     = in_valid_i && !skid_vld_q;
  assign out_take   = out_vld_q && !out_stall_i;
  assign accept_o   = accept;

  // Output register with skid: fill the output when it drains, else park
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_take || !out_vld_q) begin
      out_vld_q  <= skid_vld_q || accept;
      skid_vld_q <= 1'b0;
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_vld_q) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= merged;
      end
    end else if (accept) begin
      skid_q <= merged;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = out_q;

  // The skid register only fills behind a held output beat
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full with output register empty");

  // A release cannot be long and double-long at once
  a_long_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.long_events & out_q.double_long_events) == '0))
    else $error("long and double-long on the same switch");

  // Double events come with a press, long events with a release
  a_double_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.double_events & ~out_q.pressed_mask) == '0))
    else $error("double event on a released switch");

  a_long_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (((out_q.long_events | out_q.double_long_events)
                    & out_q.pressed_mask) == '0))
    else $error("long event on a pressed switch");

endmodule

// ===== hdl/footswitch_gesture_detector.sv =====
// Footswitch gesture detector: one poll per cycle while the poll side is not
// stalled, one result per poll. A poll is a timestamp plus raw pin levels; its
// result beat goes into the output register, or into the skid stage while the
// output beat is held. Each switch has its own lane that debounces the pin,
// counts clicks and times the hold with two 32-bit subtractions feeding three
// compares; these set the clock rate. An output register with a skid stage
// holds up to two finished beats. A poll is still taken while the consumer
// stalls, unless the skid stage is full; it fills when a poll is taken while
// the consumer stalls on a full output register. A pin reading low is pressed.
// Configuration sits on the APB port at byte addresses 0, 4 and 8.
module footswitch_gesture_detector #(
  parameter int unsigned NUM_SWITCHES = fgd_pkg::NumSwitchesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fgd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [fgd_pkg::ApbDataW-1:0]  pwdata,
  output logic [fgd_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  // Poll channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fgd_pkg::TimeW-1:0]     now_ms_i,
  input  logic [fgd_pkg::FieldW-1:0]    pin_levels_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fgd_pkg::FieldW-1:0]    pressed_mask_o,
  output logic [fgd_pkg::FieldW-1:0]    double_events_o,
  output logic [fgd_pkg::FieldW-1:0]    long_events_o,
  output logic [fgd_pkg::FieldW-1:0]    double_long_events_o
);
  import fgd_pkg::*;

  cfg_t      cfg;
  logic      accept;
  lane_res_t lane_res [NUM_SWITCHES];
  result_t   result;

  fgd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // One lane per switch; switches past the pin field read as pressed
  for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_lane
    logic raw_pressed;
    if (i < FieldW) begin : g_pin
      assign raw_pressed = !pin_levels_i[i];
    end else begin : g_nopin
      assign raw_pressed = 1'b1;
    end

    fgd_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .accept_i      (accept),
      .now_i         (now_ms_i),
      .raw_pressed_i (raw_pressed),
      .cfg_i         (cfg),
      .res_o         (lane_res[i])
    );
  end

  fgd_merge #(
    .NumSwitches (NUM_SWITCHES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .accept_o    (accept),
    .lane_res_i  (lane_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign pressed_mask_o       = result.pressed_mask;
  assign double_events_o      = result.double_events;
  assign long_events_o        = result.long_events;
  assign double_long_events_o = result.double_long_events;

endmodule
